// File: hw/rtl/nth_order_row_difference_assert.svh
// Assertion macros for the row difference block.
`ifndef NTH_ORDER_ROW_DIFFERENCE_ASSERT_SVH
`define NTH_ORDER_ROW_DIFFERENCE_ASSERT_SVH
`ifndef SYNTH
`define NORD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nord: same-cycle check failed");
`define NORD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nord: next-cycle check failed");
`else
`define NORD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define NORD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/nord_pkg.sv
package nord_pkg;

    localparam int unsigned MaxOrderDef    = 8;
    localparam int unsigned MaxRowDef      = 4096;
    localparam int unsigned SampleWidthDef = 32;

    localparam int unsigned OrderW    = 4;
    localparam int unsigned RowLenW   = 13;
    localparam int unsigned ScaleW    = 32;
    localparam int unsigned OutW      = 48;
    localparam int unsigned FracBits  = 16;
    localparam int unsigned CfgIdxW   = 2;
    localparam int unsigned CfgDataW  = 32;

    localparam int unsigned OrderRst    = 1;
    localparam int unsigned RowLenRst   = 4096;
    localparam int unsigned InvScaleRst = 65536;

    typedef enum logic [CfgIdxW-1:0] {
        CfgOrder    = 2'd0,
        CfgRowLen   = 2'd1,
        CfgInvScale = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic emit;
        logic last;
    } t_meta;

endpackage

// File: hw/rtl/nth_order_row_difference.sv
// Streaming n-th order forward difference along a row. Samples enter one per cycle into a
// row of MAX_ORDER difference cells, each holding one delay register; cells past the
// configured order pass the beat through unchanged. The difference is then multiplied by
// the Q16.16 reciprocal in two half-width partial products, rounded and saturated to
// 48 bits. The block takes one sample beat every cycle; the input stalls only while a
// finished result waits in the output register. The first n samples of each row give no
// result, and the final result of a row carries the last-in-row flag. Configuration is to
// be written while idle; the block itself does not enforce this.
`include "nth_order_row_difference_assert.svh"

module nth_order_row_difference #(
    parameter int unsigned MAX_ORDER    = nord_pkg::MaxOrderDef,
    parameter int unsigned MAX_ROW      = nord_pkg::MaxRowDef,
    parameter int unsigned SAMPLE_WIDTH = nord_pkg::SampleWidthDef
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [nord_pkg::CfgIdxW-1:0]         i_cfg_index,
    input  logic [nord_pkg::CfgDataW-1:0]        i_cfg_wdata,
    input  logic                                 i_sample_valid,
    output logic                                 o_sample_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_sample,
    output logic                                 o_result_valid,
    input  logic                                 i_result_ready,
    output logic signed [nord_pkg::OutW-1:0]     o_deriv_value,
    output logic                                 o_last_in_row
);

    localparam int unsigned StageW = SAMPLE_WIDTH + MAX_ORDER;
    localparam int unsigned LenW   = nord_pkg::RowLenW;
    localparam int unsigned OrdW   = nord_pkg::OrderW + 1;
    localparam int unsigned LenMax = (1 << LenW) - 1;
    localparam int unsigned LenCap = (MAX_ROW < LenMax) ? MAX_ROW : LenMax;
    localparam int unsigned OrdCap = (MAX_ORDER < ((1 << OrdW) - 1)) ? MAX_ORDER
                                                                     : ((1 << OrdW) - 1);

    logic [nord_pkg::OrderW-1:0]        r_order;
    logic [LenW-1:0]                    r_row_len;
    logic signed [nord_pkg::ScaleW-1:0] r_inv_scale;
    logic [LenW-1:0]                    r_pos;
    logic [LenW-1:0]                    n_pos;

    logic [OrdW-1:0] w_order;
    logic [LenW-1:0] w_len;
    logic [LenW:0]   w_pos_inc;
    logic            w_last;
    logic            w_accept;
    logic            w_adv;

    logic              w_valid  [MAX_ORDER+1];
    nord_pkg::t_meta   w_meta   [MAX_ORDER+1];
    logic [StageW-1:0] w_value  [MAX_ORDER+1];
    logic              w_active [MAX_ORDER];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order     <= nord_pkg::OrderW'(nord_pkg::OrderRst);
            r_row_len   <= LenW'(nord_pkg::RowLenRst);
            r_inv_scale <= nord_pkg::ScaleW'(nord_pkg::InvScaleRst);
        end else if (i_cfg_wr_en) begin
            case (nord_pkg::t_cfg_idx'(i_cfg_index))
                nord_pkg::CfgOrder: begin
                    r_order <= i_cfg_wdata[nord_pkg::OrderW-1:0];
                end
                nord_pkg::CfgRowLen: begin
                    r_row_len <= i_cfg_wdata[LenW-1:0];
                end
                nord_pkg::CfgInvScale: begin
                    r_inv_scale <= i_cfg_wdata[nord_pkg::ScaleW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_order == '0) begin
            w_order = OrdW'(1);
        end else if ({1'b0, r_order} > OrdW'(OrdCap)) begin
            w_order = OrdW'(OrdCap);
        end else begin
            w_order = {1'b0, r_order};
        end
    end

    always_comb begin
        if (r_row_len < LenW'(2)) begin
            w_len = LenW'(2);
        end else if (r_row_len > LenW'(LenCap)) begin
            w_len = LenW'(LenCap);
        end else begin
            w_len = r_row_len;
        end
    end

    assign w_adv          = !o_result_valid || i_result_ready;
    assign o_sample_ready = w_adv;
    assign w_accept       = i_sample_valid && o_sample_ready;

    assign w_pos_inc = {1'b0, r_pos} + (LenW+1)'(1);
    assign w_last    = w_pos_inc >= {1'b0, w_len};
    assign n_pos     = w_last ? '0 : w_pos_inc[LenW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (w_accept) begin
            r_pos <= n_pos;
        end
    end

    assign w_valid[0]     = w_accept;
    assign w_meta[0].emit = (r_pos >= LenW'(w_order)) && (LenW'(w_order) < w_len);
    assign w_meta[0].last = w_last;
    assign w_value[0]     = StageW'(i_sample);

    for (genvar k = 0; k < MAX_ORDER; k++) begin : g_cell
        assign w_active[k] = OrdW'(k) < w_order;

        nord_cell #(
            .StageW (StageW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (w_adv),
            .i_active (w_active[k]),
            .i_valid  (w_valid[k]),
            .i_meta   (w_meta[k]),
            .i_value  (w_value[k]),
            .o_valid  (w_valid[k+1]),
            .o_meta   (w_meta[k+1]),
            .o_value  (w_value[k+1])
        );
    end

    nord_scale #(
        .StageW (StageW)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_valid[MAX_ORDER] && w_meta[MAX_ORDER].emit),
        .i_last  (w_meta[MAX_ORDER].last),
        .i_diff  ($signed(w_value[MAX_ORDER])),
        .i_scale (r_inv_scale),
        .o_valid (o_result_valid),
        .o_last  (o_last_in_row),
        .o_value (o_deriv_value)
    );

    `NORD_ASSERT_IMPLY(a_stall_blocks_input, i_clk, i_rst_n, o_result_valid && !i_result_ready, !o_sample_ready)
    `NORD_ASSERT_NEXT(a_row_end_wraps, i_clk, i_rst_n, w_accept && w_last, r_pos == '0)
    `NORD_ASSERT_IMPLY(a_row_head_silent, i_clk, i_rst_n, w_accept && (r_pos == '0), !w_meta[0].emit)

endmodule

// File: hw/rtl/nord_cell.sv
module nord_cell #(
    parameter int unsigned StageW = nord_pkg::SampleWidthDef + nord_pkg::MaxOrderDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_active,
    input  logic                i_valid,
    input  nord_pkg::t_meta     i_meta,
    input  logic [StageW-1:0]   i_value,
    output logic                o_valid,
    output nord_pkg::t_meta     o_meta,
    output logic [StageW-1:0]   o_value
);

    logic [StageW-1:0] r_delay;
    logic              r_valid;
    nord_pkg::t_meta   r_meta;
    logic [StageW-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= '0;
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
            if (i_valid && i_active) begin
                r_delay <= i_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_meta  <= i_meta;
            r_value <= i_active ? (i_value - r_delay) : i_value;
        end
    end

    assign o_valid = r_valid;
    assign o_meta  = r_meta;
    assign o_value = r_value;

endmodule

// File: hw/rtl/nord_scale.sv
module nord_scale #(
    parameter int unsigned StageW = nord_pkg::SampleWidthDef + nord_pkg::MaxOrderDef
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  logic                                i_valid,
    input  logic                                i_last,
    input  logic signed [StageW-1:0]            i_diff,
    input  logic signed [nord_pkg::ScaleW-1:0]  i_scale,
    output logic                                o_valid,
    output logic                                o_last,
    output logic signed [nord_pkg::OutW-1:0]    o_value
);

    localparam int unsigned LoW = StageW / 2;
    localparam int unsigned HiW = StageW - LoW;
    localparam int unsigned PW  = StageW + nord_pkg::ScaleW;
    localparam int unsigned RW  = PW - nord_pkg::FracBits;
    localparam int unsigned EW  = (RW > nord_pkg::OutW) ? RW : nord_pkg::OutW;
    localparam int unsigned OW  = nord_pkg::OutW;

    logic signed [LoW+nord_pkg::ScaleW:0]   n_plo;
    logic signed [HiW+nord_pkg::ScaleW-1:0] n_phi;
    logic signed [LoW+nord_pkg::ScaleW:0]   r_plo;
    logic signed [HiW+nord_pkg::ScaleW-1:0] r_phi;
    logic                                   r_m1_valid;
    logic                                   r_m1_last;

    logic signed [PW-1:0] w_prod;
    logic signed [PW-1:0] w_bias;
    logic signed [PW-1:0] w_sum;
    logic signed [RW-1:0] r_round;
    logic                 r_m2_valid;
    logic                 r_m2_last;

    logic signed [EW-1:0] w_ext;
    logic [EW-OW:0]       w_top;
    logic signed [OW-1:0] n_value;
    logic signed [OW-1:0] r_value;
    logic                 r_valid;
    logic                 r_last;

    // The difference is split into an unsigned low half and a signed high half.
    assign n_plo = $signed({1'b0, i_diff[LoW-1:0]}) * i_scale;
    assign n_phi = $signed(i_diff[StageW-1:LoW]) * i_scale;

    // Halves round away from zero, so a negative product takes one less.
    assign w_prod = ($signed(PW'(r_phi)) <<< LoW) + $signed(PW'(r_plo));
    assign w_bias = w_prod[PW-1] ? $signed(PW'(16'h7FFF)) : $signed(PW'(16'h8000));
    assign w_sum  = w_prod + w_bias;

    assign w_ext = EW'(r_round);
    assign w_top = w_ext[EW-1:OW-1];

    always_comb begin
        if ((&w_top) || !(|w_top)) begin
            n_value = w_ext[OW-1:0];
        end else if (w_ext[EW-1]) begin
            n_value = {1'b1, {(OW-1){1'b0}}};
        end else begin
            n_value = {1'b0, {(OW-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
            r_m2_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else if (i_adv) begin
            r_m1_valid <= i_valid;
            r_m2_valid <= r_m1_valid;
            r_valid    <= r_m2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_plo     <= n_plo;
            r_phi     <= n_phi;
            r_m1_last <= i_last;
            r_round   <= w_sum[PW-1:nord_pkg::FracBits];
            r_m2_last <= r_m1_last;
            r_value   <= n_value;
            r_last    <= r_m2_last;
        end
    end

    assign o_valid = r_valid;
    assign o_last  = r_last;
    assign o_value = r_value;

endmodule

// File: test/nth_order_row_difference_tb.sv
module nth_order_row_difference_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MaxOrder = nord_pkg::MaxOrderDef;
    localparam int unsigned MaxRow   = nord_pkg::MaxRowDef;
    localparam int unsigned SampleW  = nord_pkg::SampleWidthDef;
    localparam int unsigned OrderW   = nord_pkg::OrderW;
    localparam int unsigned RowLenW  = nord_pkg::RowLenW;
    localparam int unsigned ScaleW   = nord_pkg::ScaleW;
    localparam int unsigned OutW     = nord_pkg::OutW;
    localparam int unsigned FracBits = nord_pkg::FracBits;
    localparam int unsigned CfgIdxW  = nord_pkg::CfgIdxW;
    localparam int unsigned CfgDataW = nord_pkg::CfgDataW;
    localparam int unsigned StageW   = SampleW + MaxOrder;
    localparam int unsigned ProdW    = StageW + ScaleW;

    localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

    localparam int SettleCycles  = 2 * (MaxOrder + 3);
    localparam int WatchdogLimit = 4000;
    localparam int RandomPhases  = 12;
    localparam int MaxPrinted    = 40;

    typedef struct packed {
        logic [OutW-1:0] deriv;
        logic            last;
    } t_deriv_beat;

    class row_diff_scoreboard;
        logic [StageW-1:0]  taps [MaxOrder];
        logic [RowLenW-1:0] position;
        logic [OrderW-1:0]  order_reg;
        logic [RowLenW-1:0] row_len_reg;
        logic [ScaleW-1:0]  scale_reg;
        t_deriv_beat        pending_derivs [$];
        int                 mismatches;
        int                 samples_in;
        int                 derivs_checked;

        function new();
            foreach (taps[k]) taps[k] = '0;
            position       = '0;
            order_reg      = OrderW'(nord_pkg::OrderRst);
            row_len_reg    = RowLenW'(nord_pkg::RowLenRst);
            scale_reg      = ScaleW'(nord_pkg::InvScaleRst);
            mismatches     = 0;
            samples_in     = 0;
            derivs_checked = 0;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
            case (idx)
                nord_pkg::CfgOrder:    order_reg   = data[OrderW-1:0];
                nord_pkg::CfgRowLen:   row_len_reg = data[RowLenW-1:0];
                nord_pkg::CfgInvScale: scale_reg   = data[ScaleW-1:0];
                default: ;
            endcase
        endfunction

        // Sign-magnitude multiply, round half away from zero, saturate to the output width.
        function logic [OutW-1:0] scale_diff(logic [StageW-1:0] d, logic [ScaleW-1:0] sc);
            logic [StageW-1:0] dm;
            logic [ScaleW-1:0] sm;
            logic [ProdW-1:0]  prod;
            logic [ProdW-1:0]  q;
            logic [ProdW-1:0]  lim;
            logic              neg;
            neg  = d[StageW-1] ^ sc[ScaleW-1];
            dm   = d[StageW-1] ? ~d + 1'b1 : d;
            sm   = sc[ScaleW-1] ? ~sc + 1'b1 : sc;
            prod = {{ScaleW{1'b0}}, dm} * {{StageW{1'b0}}, sm};
            q    = (prod + (ProdW'(1) << (FracBits - 1))) >> FracBits;
            lim  = neg ? (ProdW'(1) << (OutW - 1)) : ((ProdW'(1) << (OutW - 1)) - 1'b1);
            if (q > lim) q = lim;
            if (neg) q = ~q + 1'b1;
            return q[OutW-1:0];
        endfunction

        function void note_sample(logic [SampleW-1:0] s);
            logic [StageW-1:0] v;
            logic [StageW-1:0] prev;
            int                n;
            int                len;
            int                p;
            logic              last;
            t_deriv_beat       beat;
            n   = order_reg;
            len = row_len_reg;
            if (n < 1) n = 1;
            if (n > MaxOrder) n = MaxOrder;
            if (len < 2) len = 2;
            if (len > MaxRow) len = MaxRow;
            p = position;
            v = {{MaxOrder{s[SampleW-1]}}, s};
            for (int k = 0; k < n; k++) begin
                prev    = taps[k];
                taps[k] = v;
                v       = v - prev;
            end
            last     = (p + 1 >= len);
            position = last ? '0 : RowLenW'(p + 1);
            samples_in++;
            if (p >= n && n < len) begin
                beat.deriv = scale_diff(v, scale_reg);
                beat.last  = last;
                pending_derivs.push_back(beat);
            end
        endfunction

        task report(string msg);
            if (mismatches < MaxPrinted) $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_result(logic [OutW-1:0] deriv, logic last);
            t_deriv_beat want;
            if (pending_derivs.size() == 0) begin
                report($sformatf("result beat %h with none expected", deriv));
                return;
            end
            want = pending_derivs.pop_front();
            derivs_checked++;
            if (deriv !== want.deriv)
                report($sformatf("beat %0d value %h, expected %h", derivs_checked, deriv,
                                 want.deriv));
            if (last !== want.last)
                report($sformatf("beat %0d last flag %b, expected %b", derivs_checked, last,
                                 want.last));
        endtask
    endclass

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_wr_en    = 1'b0;
    logic [CfgIdxW-1:0]   i_cfg_index    = nord_pkg::CfgOrder;
    logic [CfgDataW-1:0]  i_cfg_wdata    = '0;
    logic                 i_sample_valid = 1'b0;
    logic                 o_sample_ready;
    logic [SampleW-1:0]   i_sample       = '0;
    logic                 o_result_valid;
    logic                 i_result_ready = 1'b0;
    logic [OutW-1:0]      o_deriv_value;
    logic                 o_last_in_row;

    row_diff_scoreboard sb;
    int                 settings_used = 0;
    int                 quiet_cycles  = 0;
    int                 ready_cycle   = 0;
    logic [15:0]        stall_pattern = '1;

    nth_order_row_difference uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample       (i_sample),
        .o_result_valid (o_result_valid),
        .i_result_ready (i_result_ready),
        .o_deriv_value  (o_deriv_value),
        .o_last_in_row  (o_last_in_row)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        ready_cycle <= ready_cycle + 1;
        if (ready_cycle % 48 == 0) begin
            stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        end else begin
            stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
        end
        i_result_ready <= stall_pattern[0];
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid && i_result_ready) begin
            sb.check_result(o_deriv_value, o_last_in_row);
        end
    end

    always @(posedge i_clk) begin
        if ((i_sample_valid && o_sample_ready) || (o_result_valid && i_result_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_sample(logic [SampleW-1:0] s);
        i_sample_valid <= 1'b1;
        i_sample       <= s;
        @(posedge i_clk);
        while (!o_sample_ready) @(posedge i_clk);
        sb.note_sample(s);
    endtask

    task automatic rest_sender(int cycles);
        if (cycles > 0) begin
            i_sample_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_sample_valid <= 1'b0;
        for (int w = 0; w < WatchdogLimit && sb.pending_derivs.size() != 0; w++)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_config(logic [CfgDataW-1:0] ord_w, logic [CfgDataW-1:0] len_w,
                              logic [CfgDataW-1:0] scale_w, bit poke_unused);
        drain();
        write_cfg(nord_pkg::CfgOrder, ord_w);
        write_cfg(nord_pkg::CfgRowLen, len_w);
        if (poke_unused) write_cfg(CfgUnused, $urandom);
        write_cfg(nord_pkg::CfgInvScale, scale_w);
        i_cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    initial begin
        int               count;
        int               gap_max;
        int               burst_left;
        int               ord;
        int               rlen;
        logic [ScaleW-1:0]  scl;
        logic [SampleW-1:0] smp;

        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register values after reset: first order, full-length row, unit scale.
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0001);

        // The row is shortened below the current position, so the next beat closes it.
        set_config(2, 3, 32'h0001_0000, 1'b0);
        send_sample(32'h0000_8000);
        send_sample(32'h0000_0000);
        send_sample(32'h0001_0000);

        // Order above the maximum, largest scale, alternating extremes.
        set_config(15, 9, 32'h7FFF_FFFF, 1'b0);
        for (int j = 0; j < 9; j++) send_sample(j[0] ? 32'h8000_0000 : 32'h7FFF_FFFF);

        // Order and row length below their minimums; halves round away from zero.
        set_config(0, 1, 32'h0000_0001, 1'b1);
        send_sample(32'h0000_0000);
        send_sample(32'h0000_0000);
        send_sample(32'h0000_8000);
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_8000);

        // Order not below the row length: no results at all.
        set_config(8, 5, 32'h8000_0000, 1'b0);
        for (int j = 0; j < 4; j++) send_sample($urandom);

        for (int ph = 0; ph < RandomPhases; ph++) begin
            ord = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            case ($urandom_range(0, 19))
                0, 1:         rlen = $urandom_range(0, 1);
                2:            rlen = ($urandom_range(0, 1) == 0) ? 4096 : 8191;
                3:            rlen = $urandom_range(4097, 8191);
                4, 5, 6:      rlen = $urandom_range(25, 300);
                7, 8, 9, 10:  rlen = $urandom_range((ord > 8) ? 8 : ord, ord + 2);
                default:      rlen = $urandom_range(2, 24);
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2: scl = 32'h0001_0000;
                3:       scl = 32'h7FFF_FFFF;
                4:       scl = 32'h8000_0000;
                5:       scl = ScaleW'($urandom_range(0, 255));
                6:       scl = -ScaleW'($urandom_range(1, 4) << 16);
                default: scl = $urandom;
            endcase
            set_config({28'($urandom_range(0, 32'h0FFF_FFFF)), 4'(ord)},
                       {16'($urandom_range(0, 16'h7FFF)), 3'b000, 13'(rlen)},
                       scl, $urandom_range(0, 2) == 0);
            count      = $urandom_range(120, 220);
            gap_max    = (ph % 4 == 1) ? 0 : $urandom_range(1, 8);
            burst_left = 0;
            for (int j = 0; j < count; j++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 32);
                    rest_sender($urandom_range(0, gap_max));
                end
                if ($urandom_range(0, 399) == 0) drain();
                case ($urandom_range(0, 9))
                    0:          smp = ($urandom_range(0, 1) == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    1, 2, 3:    smp = SampleW'($urandom_range(0, 2000)) - SampleW'(1000);
                    4:          smp = SampleW'($urandom_range(0, 3)) << 15;
                    default:    smp = $urandom;
                endcase
                send_sample(smp);
                burst_left--;
            end
        end

        drain();
        if (sb.pending_derivs.size() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending_derivs.size()));
        $display("summary: %0d sample beats in, %0d result beats checked, %0d register settings",
                 sb.samples_in, sb.derivs_checked, settings_used + 1);
        $display("summary: %0d mismatches", sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
